// ===== src/gbn_pkg.sv =====
package gbn_pkg;

  localparam int TAG_W = 16;

  typedef enum logic [1:0] {
    ACT_PACKET    = 2'd0,
    ACT_PHY_READY = 2'd1,
    ACT_FRAME     = 2'd2,
    ACT_TIMEOUT   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    FRM_DATA   = 2'd0,
    FRM_ACK    = 2'd1,
    FRM_NAK    = 2'd2,
    FRM_UNUSED = 2'd3
  } frame_kind_t;

  typedef enum logic [2:0] {
    OUT_SEND    = 3'd0,
    OUT_ACK     = 3'd1,
    OUT_DELIVER = 3'd2,
    OUT_STOP    = 3'd3,
    OUT_STATUS  = 3'd4
  } out_kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_DELIV_ACK,
    S_ACK_LOOP,
    S_RES_RD,
    S_RES_SEND,
    S_STATUS
  } state_t;

endpackage

// ===== src/gbn_ram.sv =====
module gbn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/go_back_n_window_controller_core.sv =====
// Go-Back-N sender and receiver window control with sequence numbers modulo
// MAX_SEQ_NUM+1. Each input request is one event; the block answers with zero
// or more action results (send data and start timer, send ack, deliver, stop
// timer) followed by one status result with tlast set, which carries the
// network-enable flag and, for a refused packet, the refused flag. Events are
// handled one at a time: a new request is taken once the previous event has
// placed its status in the output register. An event is taken while idle, then
// executed, and then each action result and finally the status is registered in
// turn; a good data frame issues deliver and then ack. An ack runs a loop that
// stops one timer per acked frame, and the window test that ends the loop is a
// step of its own. A timeout rewinds the window, then resends every outstanding
// frame, up to MAX_SEQ_NUM of them; for each frame the stored tag is first read
// from the tag RAM, whose read data is registered, and then sent. Output
// back-pressure can stall any result. The tag RAM needs no initialization: only
// entries written by accepted packets are ever read.
module go_back_n_window_controller_core
  import gbn_pkg::*;
#(
  parameter int MAX_SEQ_NUM = 7
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // packet_tag, frame_ok, frame_kind, frame_seq (lowest bit up), zero padded
  input  logic [((19 + $clog2(MAX_SEQ_NUM + 1) + 7) / 8) * 8 - 1:0] s_tdata,
  // action
  input  logic [1:0] s_tuser,
  output logic m_tvalid,
  input  logic m_tready,
  // seq, out_tag, network_enable, refused (lowest bit up), zero padded
  output logic [((18 + $clog2(MAX_SEQ_NUM + 1) + 7) / 8) * 8 - 1:0] m_tdata,
  // out_kind
  output logic [2:0] m_tuser,
  output logic m_tlast
);

  localparam int SEQ_W  = $clog2(MAX_SEQ_NUM + 1);
  localparam int DEPTH  = MAX_SEQ_NUM + 1;
  localparam int OUT_W  = ((18 + SEQ_W + 7) / 8) * 8;
  localparam int OUT_USED = 18 + SEQ_W;
  localparam logic [SEQ_W-1:0] SEQ_MAX = SEQ_W'(MAX_SEQ_NUM);

  function automatic logic [SEQ_W-1:0] seq_inc(input logic [SEQ_W-1:0] k);
    return (k < SEQ_MAX) ? k + SEQ_W'(1) : '0;
  endfunction

  function automatic logic in_window(input logic [SEQ_W-1:0] a,
                                     input logic [SEQ_W-1:0] b,
                                     input logic [SEQ_W-1:0] c);
    return (a <= b && b < c) || (c < a && b < c) || (c < a && a <= b);
  endfunction

  // Latched event.
  action_t          act;
  logic [TAG_W-1:0] ev_tag;
  logic             ev_ok;
  frame_kind_t      ev_kind;
  logic [SEQ_W-1:0] ev_seq;

  // Window state.
  state_t           state, state_next;
  logic [SEQ_W-1:0] next_to_send, next_to_send_next;
  logic [SEQ_W-1:0] oldest_unacked, oldest_unacked_next;
  logic [SEQ_W-1:0] expected_rx_seq, expected_rx_seq_next;
  logic [SEQ_W-1:0] outstanding_count, outstanding_count_next;
  logic [SEQ_W-1:0] remain, remain_next;
  logic             phys_ready, phys_ready_next;
  logic             refused, refused_next;

  // Output register.
  out_kind_t        o_kind, o_kind_next;
  logic [SEQ_W-1:0] o_seq, o_seq_next;
  logic [TAG_W-1:0] o_tag, o_tag_next;
  logic             o_en, o_en_next;
  logic             o_ref, o_ref_next;
  logic             o_last, o_last_next;
  logic             emit;
  logic             out_free;

  logic             ram_we;
  logic [TAG_W-1:0] ram_rdata;
  logic             net_en;

  gbn_ram #(
    .WIDTH(TAG_W),
    .DEPTH(DEPTH)
  ) u_tag_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(next_to_send),
    .wdata(ev_tag),
    .raddr(next_to_send),
    .rdata(ram_rdata)
  );

  assign out_free = !m_tvalid || m_tready;
  assign net_en   = (outstanding_count < SEQ_MAX) && phys_ready;
  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      next_to_send      <= '0;
      oldest_unacked    <= '0;
      expected_rx_seq   <= '0;
      outstanding_count <= '0;
      phys_ready        <= 1'b0;
      refused           <= 1'b0;
      remain            <= '0;
      m_tvalid          <= 1'b0;
    end else begin
      state             <= state_next;
      next_to_send      <= next_to_send_next;
      oldest_unacked    <= oldest_unacked_next;
      expected_rx_seq   <= expected_rx_seq_next;
      outstanding_count <= outstanding_count_next;
      phys_ready        <= phys_ready_next;
      refused           <= refused_next;
      remain            <= remain_next;
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      act     <= action_t'(s_tuser);
      ev_tag  <= s_tdata[TAG_W-1:0];
      ev_ok   <= s_tdata[TAG_W];
      ev_kind <= frame_kind_t'(s_tdata[TAG_W+2:TAG_W+1]);
      ev_seq  <= s_tdata[TAG_W+3+SEQ_W-1:TAG_W+3];
    end
    if (emit) begin
      o_kind <= o_kind_next;
      o_seq  <= o_seq_next;
      o_tag  <= o_tag_next;
      o_en   <= o_en_next;
      o_ref  <= o_ref_next;
      o_last <= o_last_next;
    end
  end

  always_comb begin
    state_next             = state;
    next_to_send_next      = next_to_send;
    oldest_unacked_next    = oldest_unacked;
    expected_rx_seq_next   = expected_rx_seq;
    outstanding_count_next = outstanding_count;
    phys_ready_next        = phys_ready;
    refused_next           = refused;
    remain_next            = remain;
    ram_we                 = 1'b0;
    emit                   = 1'b0;
    o_kind_next            = OUT_STATUS;
    o_seq_next             = '0;
    o_tag_next             = '0;
    o_en_next              = 1'b0;
    o_ref_next             = 1'b0;
    o_last_next            = 1'b0;

    unique case (state)
      S_IDLE: begin
        refused_next = 1'b0;
        if (s_tvalid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (act)
          ACT_PACKET: begin
            if (!net_en) begin
              refused_next = 1'b1;
              state_next   = S_STATUS;
            end else if (out_free) begin
              ram_we                 = 1'b1;
              emit                   = 1'b1;
              o_kind_next            = OUT_SEND;
              o_seq_next             = next_to_send;
              o_tag_next             = ev_tag;
              phys_ready_next        = 1'b0;
              outstanding_count_next = outstanding_count + SEQ_W'(1);
              next_to_send_next      = seq_inc(next_to_send);
              state_next             = S_STATUS;
            end
          end
          ACT_PHY_READY: begin
            phys_ready_next = 1'b1;
            state_next      = S_STATUS;
          end
          ACT_FRAME: begin
            if (ev_ok && ev_kind == FRM_DATA && ev_seq == expected_rx_seq) begin
              if (out_free) begin
                emit        = 1'b1;
                o_kind_next = OUT_DELIVER;
                o_seq_next  = ev_seq;
                state_next  = S_DELIV_ACK;
              end
            end else if (ev_ok && ev_kind == FRM_ACK) begin
              state_next = S_ACK_LOOP;
            end else begin
              state_next = S_STATUS;
            end
          end
          ACT_TIMEOUT: begin
            // Rewind to the oldest unacked frame and resend the whole window.
            next_to_send_next = oldest_unacked;
            remain_next       = outstanding_count;
            state_next        = (outstanding_count == '0) ? S_STATUS : S_RES_RD;
          end
          default: state_next = S_STATUS;
        endcase
      end
      S_DELIV_ACK: begin
        if (out_free) begin
          emit                 = 1'b1;
          o_kind_next          = OUT_ACK;
          o_seq_next           = expected_rx_seq;
          phys_ready_next      = 1'b0;
          expected_rx_seq_next = seq_inc(expected_rx_seq);
          state_next           = S_STATUS;
        end
      end
      S_ACK_LOOP: begin
        if (outstanding_count != '0 &&
            in_window(oldest_unacked, ev_seq, next_to_send)) begin
          if (out_free) begin
            emit                   = 1'b1;
            o_kind_next            = OUT_STOP;
            o_seq_next             = oldest_unacked;
            outstanding_count_next = outstanding_count - SEQ_W'(1);
            oldest_unacked_next    = seq_inc(oldest_unacked);
          end
        end else begin
          state_next = S_STATUS;
        end
      end
      S_RES_RD: begin
        // The tag RAM is addressed by next_to_send; its data shows up next cycle.
        state_next = S_RES_SEND;
      end
      S_RES_SEND: begin
        if (out_free) begin
          emit              = 1'b1;
          o_kind_next       = OUT_SEND;
          o_seq_next        = next_to_send;
          o_tag_next        = ram_rdata;
          phys_ready_next   = 1'b0;
          next_to_send_next = seq_inc(next_to_send);
          remain_next       = remain - SEQ_W'(1);
          state_next        = (remain == SEQ_W'(1)) ? S_STATUS : S_RES_RD;
        end
      end
      S_STATUS: begin
        if (out_free) begin
          emit        = 1'b1;
          o_kind_next = OUT_STATUS;
          o_en_next   = net_en;
          o_ref_next  = refused;
          o_last_next = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign m_tuser = o_kind;
  assign m_tlast = o_last;
  assign m_tdata = {{(OUT_W - OUT_USED){1'b0}}, o_ref, o_en, o_tag, o_seq};

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    outstanding_count <= SEQ_MAX)
    else $error("outstanding count exceeds window size");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state == S_EXEC)
    else $error("accepted request did not start execution");

  a_refused_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && o_ref |-> o_last && o_kind == OUT_STATUS)
    else $error("refused flag outside a status result");

  a_resend_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == S_RES_SEND |-> remain != '0)
    else $error("resend with no frames remaining");
`endif

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
  import gbn_pkg::*;

  localparam int MAX_SEQ = 7;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_EVENTS = 134;

  typedef struct packed {
    out_kind_t   kind;
    logic [2:0]  seq;
    logic [15:0] tag;
    logic        net_en;
    logic        refused;
    logic        last;
  } gbn_result_t;

  // Tracks both windows of the link and the results each request must produce.
  class gbn_window_tracker;
    logic [2:0]     next_seq;
    logic [2:0]     base_seq;
    logic [2:0]     rx_seq;
    int unsigned    in_flight;
    bit             phy_rdy;
    logic [15:0]    tags[MAX_SEQ + 1];
    gbn_result_t    pending_results[$];
    int unsigned    errors;

    function new();
      next_seq  = '0;
      base_seq  = '0;
      rx_seq    = '0;
      in_flight = 0;
      phy_rdy   = 1'b0;
      errors    = 0;
      foreach (tags[i]) tags[i] = '0;
    endfunction

    function logic [2:0] step_seq(logic [2:0] k);
      return (k < MAX_SEQ) ? k + 3'd1 : 3'd0;
    endfunction

    // True when b lies in the circular span starting at a and ending before c.
    function bit in_span(logic [2:0] a, logic [2:0] b, logic [2:0] c);
      return (a <= b && b < c) || (c < a && b < c) || (c < a && a <= b);
    endfunction

    function bit net_enabled();
      return in_flight < MAX_SEQ && phy_rdy;
    endfunction

    function void push(out_kind_t k, logic [2:0] s, logic [15:0] t, bit en, bit rf, bit lst);
      gbn_result_t r;
      r.kind    = k;
      r.seq     = s;
      r.tag     = t;
      r.net_en  = en;
      r.refused = rf;
      r.last    = lst;
      pending_results.push_back(r);
    endfunction

    function void note_request(action_t act, logic [15:0] tag, bit ok, frame_kind_t kind,
                               logic [2:0] fseq);
      bit refused;
      refused = 1'b0;
      case (act)
        ACT_PACKET: begin
          if (!net_enabled()) begin
            refused = 1'b1;
          end else begin
            tags[next_seq] = tag;
            push(OUT_SEND, next_seq, tag, 0, 0, 0);
            phy_rdy = 1'b0;
            in_flight++;
            next_seq = step_seq(next_seq);
          end
        end
        ACT_PHY_READY: begin
          phy_rdy = 1'b1;
        end
        ACT_FRAME: begin
          if (ok && kind == FRM_DATA) begin
            if (fseq == rx_seq) begin
              push(OUT_DELIVER, fseq, '0, 0, 0, 0);
              push(OUT_ACK, rx_seq, '0, 0, 0, 0);
              phy_rdy = 1'b0;
              rx_seq = step_seq(rx_seq);
            end
          end else if (ok && kind == FRM_ACK) begin
            // Acks are cumulative: every frame up to the acked one is released.
            while (in_flight > 0 && in_span(base_seq, fseq, next_seq)) begin
              in_flight--;
              push(OUT_STOP, base_seq, '0, 0, 0, 0);
              base_seq = step_seq(base_seq);
            end
          end
        end
        ACT_TIMEOUT: begin
          next_seq = base_seq;
          repeat (in_flight) begin
            push(OUT_SEND, next_seq, tags[next_seq], 0, 0, 0);
            phy_rdy = 1'b0;
            next_seq = step_seq(next_seq);
          end
        end
      endcase
      push(OUT_STATUS, '0, '0, net_enabled(), refused, 1'b1);
    endfunction

    function void report(string field, int unsigned exp_val, int unsigned got_val);
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_val, got_val);
      errors++;
    endfunction

    function void check_result(gbn_result_t got);
      gbn_result_t exp_r;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual kind %0d seq %0d tag %0h",
                 $time, got.kind, got.seq, got.tag);
        errors++;
        return;
      end
      exp_r = pending_results.pop_front();
      if (got.kind !== exp_r.kind) report("out_kind", exp_r.kind, got.kind);
      if (got.seq !== exp_r.seq) report("seq", exp_r.seq, got.seq);
      if (got.tag !== exp_r.tag) report("out_tag", exp_r.tag, got.tag);
      if (got.net_en !== exp_r.net_en) report("network_enable", exp_r.net_en, got.net_en);
      if (got.refused !== exp_r.refused) report("refused", exp_r.refused, got.refused);
      if (got.last !== exp_r.last) report("last", exp_r.last, got.last);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;   // packet_tag, frame_ok, frame_kind, frame_seq, zero padded
  logic [1:0]  s_tuser = '0;   // action
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;        // seq, out_tag, network_enable, refused, zero padded
  logic [2:0]  m_tuser;        // out_kind
  logic        m_tlast;

  gbn_window_tracker tracker = new();
  int unsigned       events_sent = 0;
  int unsigned       results_seen = 0;
  int unsigned       idle_cycles = 0;

  go_back_n_window_controller_core #(.MAX_SEQ_NUM(MAX_SEQ)) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Calm stretches draw no pause at all, so back-to-back traffic is covered too.
  function automatic int unsigned pause_len(bit calm);
    return calm ? 0 : $urandom_range(0, 12);
  endfunction

  task automatic issue(input action_t act, input logic [15:0] tag = '0, input bit ok = 1'b0,
                       input frame_kind_t kind = FRM_DATA, input logic [2:0] fseq = '0);
    int unsigned gap;
    gap = pause_len((events_sent / 24) % 3 == 2);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {2'b00, fseq, kind, ok, tag};
    do @(posedge clk); while (!s_tready);
    tracker.note_request(act, tag, ok, kind, fseq);
    events_sent++;
  endtask

  function automatic logic [15:0] any_tag();
    return 16'($urandom_range(0, 65535));
  endfunction

  initial begin
    logic [2:0]  seq_pick;
    int unsigned pick;
    logic [15:0] dir_tags[7];
    dir_tags = '{16'hFFFF, 16'h0000, 16'hA5A5, 16'h5A5A, 16'h8001, 16'h7FFE, 16'h1234};
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part: empty-window timeout, refusal while the link is not ready,
    // bad, good, out-of-order, nak and unused frames, then a full window.
    issue(ACT_TIMEOUT);
    issue(ACT_PACKET, 16'hBEEF);
    issue(ACT_FRAME, '0, 1'b0, FRM_DATA, 3'd0);
    issue(ACT_FRAME, 16'hFFFF, 1'b1, FRM_DATA, 3'd0);
    issue(ACT_FRAME, '0, 1'b1, FRM_DATA, 3'd7);
    issue(ACT_FRAME, '0, 1'b1, FRM_NAK, 3'd1);
    issue(ACT_FRAME, '0, 1'b1, FRM_UNUSED, 3'd1);
    foreach (dir_tags[i]) begin
      issue(ACT_PHY_READY);
      issue(ACT_PACKET, dir_tags[i]);
    end
    issue(ACT_PHY_READY);
    issue(ACT_PACKET, 16'hC0DE);
    issue(ACT_TIMEOUT);
    issue(ACT_FRAME, '0, 1'b1, FRM_ACK, 3'd7);
    issue(ACT_FRAME, '0, 1'b1, FRM_ACK, 3'd6);

    // Random part: mostly well-formed exchanges with some noise mixed in.
    while (events_sent < 26 + RANDOM_EVENTS) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        issue(ACT_PHY_READY);
        issue(ACT_PACKET, any_tag());
      end else if (pick < 50) begin
        if (tracker.in_flight > 0)
          seq_pick = 3'((tracker.base_seq + $urandom_range(0, tracker.in_flight - 1))
                        % (MAX_SEQ + 1));
        else
          seq_pick = 3'($urandom_range(0, 7));
        issue(ACT_FRAME, any_tag(), 1'b1, FRM_ACK, seq_pick);
      end else if (pick < 70) begin
        seq_pick = ($urandom_range(0, 3) != 0) ? tracker.rx_seq : 3'($urandom_range(0, 7));
        issue(ACT_FRAME, any_tag(), 1'b1, FRM_DATA, seq_pick);
      end else if (pick < 78) begin
        issue(ACT_TIMEOUT, any_tag());
      end else begin
        issue(action_t'($urandom_range(0, 3)), any_tag(), 1'($urandom_range(0, 1)),
              frame_kind_t'($urandom_range(0, 3)), 3'($urandom_range(0, 7)));
      end
    end
    s_tvalid <= 1'b0;

    while (tracker.pending_results.size() != 0) @(posedge clk);
    // Leave room for any stray result that should not come.
    repeat (60) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("[go_back_n_window_controller_core] OK");
    end else begin
      $display("[go_back_n_window_controller_core] ERROR");
    end
    $finish;
  end

  initial begin
    gbn_result_t got;
    int unsigned stall;
    do @(posedge clk); while (rst);
    forever begin
      stall = pause_len((results_seen / 30) % 3 == 1);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      got.kind    = out_kind_t'(m_tuser);
      got.seq     = m_tdata[2:0];
      got.tag     = m_tdata[18:3];
      got.net_en  = m_tdata[19];
      got.refused = m_tdata[20];
      got.last    = m_tlast;
      tracker.check_result(got);
      results_seen++;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[go_back_n_window_controller_core] ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule

// ===== sim.f =====
src/gbn_pkg.sv
src/gbn_ram.sv
src/go_back_n_window_controller_core.sv
dv/tb_top.sv
